// ===== rtl/core/wtss_pkg.sv =====
`timescale 1ns / 1ps
// Shared constants, codes and types of the windowed Theil-Sen speed estimator.
// Used by every module of the block; depends on nothing.
package wtss_pkg;

  localparam int HALF_WIDTH = 2;
  localparam int WIN_LEN    = 2 * HALF_WIDTH + 1;
  localparam int MAX_PAIRS  = WIN_LEN * (WIN_LEN - 1) / 2;
  localparam int MIN_POINTS = 3;

  localparam int WIDX_W = $clog2(WIN_LEN);
  localparam int CNT_W  = $clog2(WIN_LEN + 1);
  localparam int SIDX_W = $clog2(MAX_PAIRS);
  localparam int PAIR_W = $clog2(MAX_PAIRS + 1);

  localparam int PROD_W  = 42;
  localparam int SLOPE_W = PROD_W + 1;
  localparam int ACC_W   = 66;

  localparam int FIFO_DEPTH = 2;
  localparam int FPTR_W     = $clog2(FIFO_DEPTH);
  localparam int FCNT_W     = $clog2(FIFO_DEPTH + 1);

  localparam logic [22:0] MM_PER_UDEG_Q16 = 23'd7287271;
  localparam logic signed [27:0] LAT_LIMIT = 28'sd90000000;
  localparam logic signed [28:0] LON_LIMIT = 29'sd180000000;
  localparam logic signed [30:0] HALF_TURN = 31'sd180000000;
  localparam logic signed [30:0] FULL_TURN = 31'sd360000000;
  localparam logic signed [30:0] TWO_TURNS = 31'sd720000000;

  localparam int FLAG_SEG = 0;
  localparam int FLAG_ALT = 1;
  localparam int FLAG_POS = 2;

  localparam int CFG_IDX_W = 3;
  localparam int CFG_DAT_W = 29;
  localparam logic [CFG_IDX_W-1:0] CFG_GPS_MODE = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_REF_LAT  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_REF_LON  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_COS_REF  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_MAX_SPAN = 3'd4;

  typedef struct packed {
    logic               gps_mode;
    logic signed [27:0] ref_lat;
    logic signed [28:0] ref_lon;
    logic [16:0]        cos_ref;
    logic [15:0]        max_span;
  } cfg_t;

  typedef struct packed {
    logic [31:0]        time_ms;
    logic signed [31:0] alt;
    logic signed [31:0] east;
    logic signed [31:0] north;
    logic               seg_ok;
    logic               alt_ok;
    logic               pos_ok;
    logic               last;
  } sample_t;

endpackage

// ===== rtl/core/wtss_front.sv =====
`timescale 1ns / 1ps
// Front end: takes one sample, checks the position and converts it to east and
// north millimetres with one shared multiplier. Depends on wtss_pkg.
module wtss_front import wtss_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  cfg_t        cfg,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [127:0] s_tdata,  // time_ms, altitude_mm, lat_udeg, lon_udeg, zero fill
  input  logic [2:0]  s_tuser,   // seg_ok, alt_ok, coord_ok
  input  logic        s_tlast,
  output logic        f_valid,
  input  logic        f_ready,
  output sample_t     f_data
);

  localparam logic [3:0] F_IDLE = 4'd0;
  localparam logic [3:0] F_WRAP = 4'd1;
  localparam logic [3:0] F_M1   = 4'd2;
  localparam logic [3:0] F_R1   = 4'd3;
  localparam logic [3:0] F_M2   = 4'd4;
  localparam logic [3:0] F_R2   = 4'd5;
  localparam logic [3:0] F_M3   = 4'd6;
  localparam logic [3:0] F_R3   = 4'd7;
  localparam logic [3:0] F_PUSH = 4'd8;

  logic [3:0]         state;
  logic [31:0]        time_ms;
  logic signed [31:0] alt;
  logic               seg_ok;
  logic               alt_ok;
  logic               pos_ok;
  logic               last;
  logic signed [29:0] lon_d;
  logic signed [28:0] lat_d;
  logic [27:0]        lon_mag;
  logic               lon_neg;
  logic [28:0]        lat_mag;
  logic               lat_neg;
  logic [34:0]        e_mag;
  logic [57:0]        prod;
  logic signed [31:0] east;
  logic signed [31:0] north;

  logic signed [27:0] in_lat;
  logic signed [28:0] in_lon;
  logic               in_pos_ok;
  logic signed [30:0] d;
  logic signed [30:0] rr;
  logic signed [30:0] w;
  logic               q_odd;
  logic [34:0]        mul_a;
  logic [22:0]        mul_b;
  logic [57:0]        prod_rnd;
  logic [41:0]        rnd;

  function automatic logic [31:0] sat32(input logic neg, input logic [41:0] mag);
    logic [31:0] res;
    if (neg) begin
      if (mag >= 42'h0_8000_0000) res = 32'h8000_0000;
      else res = 32'd0 - mag[31:0];
    end else begin
      if (mag > 42'h0_7FFF_FFFF) res = 32'h7FFF_FFFF;
      else res = mag[31:0];
    end
    return res;
  endfunction

  assign in_lat = s_tdata[91:64];
  assign in_lon = s_tdata[120:92];
  assign in_pos_ok = s_tuser[2] && (in_lat <= LAT_LIMIT) && (in_lat >= -LAT_LIMIT) &&
                     (in_lon <= LON_LIMIT) && (in_lon >= -LON_LIMIT) &&
                     !((in_lat == 28'sd0) && (in_lon == 29'sd0));

  always_comb begin
    d = 31'(lon_d);
    if (d < -FULL_TURN) begin
      rr = d + TWO_TURNS;
      q_odd = 1'b0;
    end else if (d < 31'sd0) begin
      rr = d + FULL_TURN;
      q_odd = 1'b1;
    end else if (d < FULL_TURN) begin
      rr = d;
      q_odd = 1'b0;
    end else begin
      rr = d - FULL_TURN;
      q_odd = 1'b1;
    end
    if (rr > HALF_TURN) w = rr - FULL_TURN;
    else if ((rr == HALF_TURN) && q_odd) w = -HALF_TURN;
    else w = rr;
  end

  always_comb begin
    case (state)
      F_M1: begin
        mul_a = 35'(lon_mag);
        mul_b = MM_PER_UDEG_Q16;
      end
      F_M2: begin
        mul_a = e_mag;
        mul_b = 23'(cfg.cos_ref);
      end
      default: begin
        mul_a = 35'(lat_mag);
        mul_b = MM_PER_UDEG_Q16;
      end
    endcase
  end

  assign prod_rnd = prod + 58'd32768;
  assign rnd = prod_rnd[57:16];

  assign s_tready = (state == F_IDLE);
  assign f_valid = (state == F_PUSH);
  assign f_data = '{time_ms: time_ms, alt: alt, east: pos_ok ? east : 32'sd0,
                    north: pos_ok ? north : 32'sd0, seg_ok: seg_ok, alt_ok: alt_ok,
                    pos_ok: pos_ok, last: last};

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= F_IDLE;
    end else begin
      prod <= mul_a * mul_b;
      case (state)
        F_IDLE: begin
          if (s_tvalid) begin
            time_ms <= s_tdata[31:0];
            alt     <= s_tdata[63:32];
            seg_ok  <= s_tuser[0];
            alt_ok  <= s_tuser[1];
            last    <= s_tlast;
            pos_ok  <= in_pos_ok;
            lon_d   <= 30'(in_lon) - 30'(cfg.ref_lon);
            lat_d   <= 29'(in_lat) - 29'(cfg.ref_lat);
            state   <= F_WRAP;
          end
        end
        F_WRAP: begin
          lon_neg <= w < 31'sd0;
          lon_mag <= w < 31'sd0 ? 28'(-w) : 28'(w);
          lat_neg <= lat_d < 29'sd0;
          lat_mag <= lat_d < 29'sd0 ? 29'(-lat_d) : 29'(lat_d);
          state   <= F_M1;
        end
        F_M1: state <= F_R1;
        F_R1: begin
          e_mag <= rnd[34:0];
          state <= F_M2;
        end
        F_M2: state <= F_R2;
        F_R2: begin
          east  <= sat32(lon_neg, rnd);
          state <= F_M3;
        end
        F_M3: state <= F_R3;
        F_R3: begin
          north <= sat32(lat_neg, rnd);
          state <= F_PUSH;
        end
        F_PUSH: begin
          if (f_ready) state <= F_IDLE;
        end
        default: state <= F_IDLE;
      endcase
    end
  end

endmodule

// ===== rtl/core/wtss_fifo.sv =====
`timescale 1ns / 1ps
// Short queue of converted samples between the front and back ends.
// Depends on wtss_pkg.
module wtss_fifo import wtss_pkg::*; (
  input  logic    clk,
  input  logic    rst,
  input  logic    in_valid,
  output logic    in_ready,
  input  sample_t in_data,
  output logic    out_valid,
  input  logic    out_pop,
  output sample_t out_data
);

  sample_t           mem [FIFO_DEPTH];
  logic [FPTR_W-1:0] wp;
  logic [FPTR_W-1:0] rp;
  logic [FCNT_W-1:0] cnt;
  logic              push;
  logic              pop;

  assign in_ready  = (cnt != FCNT_W'(FIFO_DEPTH));
  assign out_valid = (cnt != '0);
  assign out_data  = mem[rp];
  assign push = in_valid && in_ready;
  assign pop  = out_pop && out_valid;

  always_ff @(posedge clk) begin
    if (push) mem[wp] <= in_data;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wp  <= '0;
      rp  <= '0;
      cnt <= '0;
    end else begin
      if (push) wp <= wp + 1'b1;
      if (pop) rp <= rp + 1'b1;
      if (push && !pop) cnt <= cnt + 1'b1;
      else if (pop && !push) cnt <= cnt - 1'b1;
    end
  end

endmodule

// ===== rtl/core/wtss_back.sv =====
`timescale 1ns / 1ps
// Back end: keeps the sample window, forms pairwise slopes with a serial divider,
// sorts them for the median; in GPS mode a serial root combines the components.
// Depends on wtss_pkg.
module wtss_back import wtss_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  cfg_t        cfg,
  input  logic        q_valid,
  input  sample_t     q_data,
  output logic        q_pop,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [31:0] out_speed,
  output logic        out_ok,
  output logic        out_last
);

  localparam logic [3:0] B_IDLE  = 4'd0;
  localparam logic [3:0] B_JOB   = 4'd1;
  localparam logic [3:0] B_CHK   = 4'd2;
  localparam logic [3:0] B_RDA   = 4'd3;
  localparam logic [3:0] B_RDB   = 4'd4;
  localparam logic [3:0] B_DLOAD = 4'd5;
  localparam logic [3:0] B_DIV   = 4'd6;
  localparam logic [3:0] B_INS   = 4'd7;
  localparam logic [3:0] B_MED1  = 4'd8;
  localparam logic [3:0] B_MED2  = 4'd9;
  localparam logic [3:0] B_ABS   = 4'd10;
  localparam logic [3:0] B_SQ    = 4'd11;
  localparam logic [3:0] B_ACC   = 4'd12;
  localparam logic [3:0] B_SQI   = 4'd13;
  localparam logic [3:0] B_SQRT  = 4'd14;
  localparam logic [3:0] B_OUT   = 4'd15;

  localparam logic [1:0] COMP_ALT   = 2'd0;
  localparam logic [1:0] COMP_EAST  = 2'd1;
  localparam logic [1:0] COMP_NORTH = 2'd2;

  localparam int DCNT_W = $clog2(PROD_W);

  logic [31:0]        win_time  [WIN_LEN];
  logic signed [31:0] win_alt   [WIN_LEN];
  logic signed [31:0] win_east  [WIN_LEN];
  logic signed [31:0] win_north [WIN_LEN];
  logic [2:0]         win_flags [WIN_LEN];

  logic [3:0]                state;
  logic [CNT_W-1:0]          fill;
  logic                      item_last;
  logic                      pend_main;
  logic [CNT_W-1:0]          tail_c;
  logic [WIDX_W-1:0]         l_idx;
  logic [WIDX_W-1:0]         a_idx;
  logic [WIDX_W-1:0]         b_idx;
  logic                      job_last;
  logic                      chk_ok;
  logic [31:0]               t_lo;
  logic [1:0]                comp;
  logic signed [31:0]        va;
  logic [31:0]               ta;
  logic signed [32:0]        dv;
  logic [31:0]               dt;
  logic [31:0]               div_rem;
  logic [PROD_W-1:0]         div_quo;
  logic                      div_neg;
  logic [DCNT_W-1:0]         div_cnt;
  logic signed [SLOPE_W-1:0] srt [MAX_PAIRS];
  logic [PAIR_W-1:0]         n_pairs;
  logic signed [SLOPE_W-1:0] med_hi;
  logic signed [SLOPE_W-1:0] median;
  logic [SLOPE_W-1:0]        mag;
  logic                      sat_any;
  logic [63:0]               sq;
  logic [ACC_W-1:0]          acc;
  logic [63:0]               sq_x;
  logic [63:0]               sq_r;
  logic [63:0]               sq_bit;
  logic [31:0]               res_speed;
  logic                      res_ok;

  logic                      win_full;
  logic [CNT_W-1:0]          fill_next;
  logic [CNT_W-1:0]          fill_m1;
  logic [WIDX_W-1:0]         r_idx;
  logic                      job_has;
  logic [WIDX_W-1:0]         job_l;
  logic                      job_lf;
  logic [CNT_W-1:0]          npts;
  logic                      in_w [WIN_LEN];
  logic                      win_ok;
  logic [WIDX_W-1:0]         rd_idx;
  logic [31:0]               rd_time;
  logic signed [31:0]        rd_val;
  logic signed [32:0]        span;
  logic                      span_bad;
  logic signed [SLOPE_W-1:0] dvx;
  logic signed [SLOPE_W-1:0] p;
  logic [32:0]               trial;
  logic                      q_bit;
  logic signed [SLOPE_W-1:0] ins_x;
  logic                      le [MAX_PAIRS];
  logic signed [SLOPE_W-1:0] s_ins [MAX_PAIRS];
  logic [PAIR_W-1:0]         half_n;
  logic [PAIR_W-1:0]         med_pos;
  logic signed [SLOPE_W-1:0] s_rd;
  logic signed [SLOPE_W:0]   med_sum;
  logic signed [SLOPE_W:0]   med_avg;
  logic [SLOPE_W-1:0]        mag_c;
  logic                      mag_big;
  logic [63:0]               sq_t;
  logic [ACC_W-1:0]          acc_next;

  assign win_full  = (fill == CNT_W'(WIN_LEN));
  assign fill_next = win_full ? fill : fill + 1'b1;
  assign fill_m1   = fill - 1'b1;
  assign r_idx     = fill_m1[WIDX_W-1:0];

  always_comb begin
    logic [CNT_W-1:0] tl;
    tl = (tail_c >= CNT_W'(HALF_WIDTH)) ? tail_c - CNT_W'(HALF_WIDTH) : '0;
    job_has = pend_main || (item_last && (tail_c < fill));
    job_l   = pend_main ? '0 : tl[WIDX_W-1:0];
    job_lf  = !pend_main && (tail_c == fill_m1);
    npts    = fill - CNT_W'(job_l);
  end

  always_comb begin
    win_ok = (npts >= CNT_W'(MIN_POINTS));
    for (int i = 0; i < WIN_LEN; i++) begin
      in_w[i] = (WIDX_W'(i) >= job_l) && (WIDX_W'(i) <= r_idx);
      if (in_w[i] && !win_flags[i][FLAG_ALT]) win_ok = 1'b0;
      if (cfg.gps_mode && in_w[i] && !win_flags[i][FLAG_POS]) win_ok = 1'b0;
    end
    for (int i = 1; i < WIN_LEN; i++) begin
      if (in_w[i] && (WIDX_W'(i) > job_l)) begin
        if (!win_flags[i][FLAG_SEG]) win_ok = 1'b0;
        if (win_time[i] <= win_time[i-1]) win_ok = 1'b0;
      end
    end
  end

  always_comb begin
    case (state)
      B_JOB:   rd_idx = job_l;
      B_CHK:   rd_idx = r_idx;
      B_RDA:   rd_idx = a_idx;
      default: rd_idx = b_idx;
    endcase
    rd_time = win_time[rd_idx];
    case (comp)
      COMP_EAST:  rd_val = win_east[rd_idx];
      COMP_NORTH: rd_val = win_north[rd_idx];
      default:    rd_val = win_alt[rd_idx];
    endcase
  end

  assign span     = $signed({1'b0, rd_time}) - $signed({1'b0, t_lo});
  assign span_bad = span > $signed({17'd0, cfg.max_span});

  assign dvx   = SLOPE_W'(dv);
  assign p     = (dvx <<< 10) - (dvx <<< 4) - (dvx <<< 3);
  assign trial = {div_rem, div_quo[PROD_W-1]};
  assign q_bit = (trial >= {1'b0, dt});

  assign ins_x = div_neg ? -$signed({1'b0, div_quo}) : $signed({1'b0, div_quo});

  always_comb begin
    for (int j = 0; j < MAX_PAIRS; j++) begin
      le[j] = (PAIR_W'(j) < n_pairs) && (srt[j] <= ins_x);
    end
    s_ins[0] = le[0] ? srt[0] : ins_x;
    for (int j = 1; j < MAX_PAIRS; j++) begin
      if (le[j]) s_ins[j] = srt[j];
      else if (le[j-1]) s_ins[j] = ins_x;
      else s_ins[j] = srt[j-1];
    end
  end

  assign half_n  = n_pairs >> 1;
  assign med_pos = (state == B_MED2) ? half_n - 1'b1 : half_n;
  assign s_rd    = srt[med_pos[SIDX_W-1:0]];
  assign med_sum = (SLOPE_W+1)'(s_rd) + (SLOPE_W+1)'(med_hi);
  assign med_avg = (med_sum + (SLOPE_W+1)'(med_sum[SLOPE_W])) >>> 1;

  assign mag_c   = median[SLOPE_W-1] ? SLOPE_W'(-median) : SLOPE_W'(median);
  assign mag_big = |mag_c[SLOPE_W-1:32];

  assign sq_t     = sq_r + sq_bit;
  assign acc_next = acc + ACC_W'(sq);

  assign q_pop = (state == B_IDLE) && q_valid;

  function automatic logic [WIDX_W-1:0] fill_m1_or_top();
    logic [WIDX_W-1:0] idx;
    idx = win_full ? WIDX_W'(WIN_LEN - 1) : fill[WIDX_W-1:0];
    return idx;
  endfunction

  always_ff @(posedge clk) begin
    if (state == B_IDLE && q_valid) begin
      for (int i = 0; i < WIN_LEN - 1; i++) begin
        if (win_full) begin
          win_time[i]  <= win_time[i+1];
          win_alt[i]   <= win_alt[i+1];
          win_east[i]  <= win_east[i+1];
          win_north[i] <= win_north[i+1];
          win_flags[i] <= win_flags[i+1];
        end
      end
      win_time[fill_m1_or_top()]  <= q_data.time_ms;
      win_alt[fill_m1_or_top()]   <= q_data.alt;
      win_east[fill_m1_or_top()]  <= q_data.east;
      win_north[fill_m1_or_top()] <= q_data.north;
      win_flags[fill_m1_or_top()] <= {q_data.pos_ok, q_data.alt_ok, q_data.seg_ok};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= B_IDLE;
      fill      <= '0;
      out_valid <= 1'b0;
    end else begin
      if (out_valid && out_ready && (state != B_OUT)) out_valid <= 1'b0;
      case (state)
        B_IDLE: begin
          if (q_valid) begin
            fill      <= fill_next;
            item_last <= q_data.last;
            pend_main <= fill_next >= CNT_W'(HALF_WIDTH + 1);
            tail_c    <= (fill_next >= CNT_W'(HALF_WIDTH + 1)) ?
                         fill_next - CNT_W'(HALF_WIDTH) : '0;
            state     <= B_JOB;
          end
        end
        B_JOB: begin
          if (job_has) begin
            l_idx    <= job_l;
            job_last <= job_lf;
            chk_ok   <= win_ok;
            t_lo     <= rd_time;
            if (pend_main) pend_main <= 1'b0;
            else tail_c <= tail_c + 1'b1;
            state <= B_CHK;
          end else begin
            if (item_last) fill <= '0;
            state <= B_IDLE;
          end
        end
        B_CHK: begin
          if (!chk_ok || span_bad) begin
            res_speed <= '0;
            res_ok    <= 1'b0;
            state     <= B_OUT;
          end else begin
            comp    <= COMP_ALT;
            a_idx   <= l_idx;
            b_idx   <= l_idx + 1'b1;
            n_pairs <= '0;
            acc     <= '0;
            sat_any <= 1'b0;
            state   <= B_RDA;
          end
        end
        B_RDA: begin
          va    <= rd_val;
          ta    <= rd_time;
          state <= B_RDB;
        end
        B_RDB: begin
          dv    <= 33'(rd_val) - 33'(va);
          dt    <= rd_time - ta;
          state <= B_DLOAD;
        end
        B_DLOAD: begin
          div_quo <= p[SLOPE_W-1] ? PROD_W'(-p) : PROD_W'(p);
          div_neg <= p[SLOPE_W-1];
          div_rem <= '0;
          div_cnt <= '0;
          state   <= B_DIV;
        end
        B_DIV: begin
          div_rem <= q_bit ? 32'(trial - {1'b0, dt}) : trial[31:0];
          div_quo <= {div_quo[PROD_W-2:0], q_bit};
          div_cnt <= div_cnt + 1'b1;
          if (div_cnt == DCNT_W'(PROD_W - 1)) state <= B_INS;
        end
        B_INS: begin
          for (int j = 0; j < MAX_PAIRS; j++) srt[j] <= s_ins[j];
          n_pairs <= n_pairs + 1'b1;
          if (b_idx == r_idx) begin
            if (a_idx + 1'b1 == r_idx) begin
              state <= B_MED1;
            end else begin
              a_idx <= a_idx + 1'b1;
              b_idx <= a_idx + 2'd2;
              state <= B_RDA;
            end
          end else begin
            b_idx <= b_idx + 1'b1;
            state <= B_RDA;
          end
        end
        B_MED1: begin
          med_hi <= s_rd;
          if (n_pairs[0]) begin
            median <= s_rd;
            state  <= B_ABS;
          end else begin
            state <= B_MED2;
          end
        end
        B_MED2: begin
          median <= SLOPE_W'(med_avg);
          state  <= B_ABS;
        end
        B_ABS: begin
          mag <= mag_c;
          if (!cfg.gps_mode) begin
            res_speed <= mag_big ? 32'hFFFF_FFFF : mag_c[31:0];
            res_ok    <= 1'b1;
            state     <= B_OUT;
          end else begin
            state <= B_SQ;
          end
        end
        B_SQ: begin
          sq <= mag[31:0] * mag[31:0];
          if (|mag[SLOPE_W-1:32]) sat_any <= 1'b1;
          state <= B_ACC;
        end
        B_ACC: begin
          acc <= acc_next;
          if (comp == COMP_NORTH) begin
            state <= B_SQI;
          end else begin
            comp    <= comp + 1'b1;
            a_idx   <= l_idx;
            b_idx   <= l_idx + 1'b1;
            n_pairs <= '0;
            state   <= B_RDA;
          end
        end
        B_SQI: begin
          if (sat_any || (|acc[ACC_W-1:64])) begin
            res_speed <= 32'hFFFF_FFFF;
            res_ok    <= 1'b1;
            state     <= B_OUT;
          end else begin
            sq_x   <= acc[63:0];
            sq_r   <= '0;
            sq_bit <= 64'h4000_0000_0000_0000;
            state  <= B_SQRT;
          end
        end
        B_SQRT: begin
          if (sq_bit == '0) begin
            res_speed <= sq_r[31:0];
            res_ok    <= 1'b1;
            state     <= B_OUT;
          end else begin
            if (sq_x >= sq_t) begin
              sq_x <= sq_x - sq_t;
              sq_r <= (sq_r >> 1) + sq_bit;
            end else begin
              sq_r <= sq_r >> 1;
            end
            sq_bit <= sq_bit >> 2;
          end
        end
        B_OUT: begin
          if (!out_valid || out_ready) begin
            out_valid <= 1'b1;
            out_speed <= res_speed;
            out_ok    <= res_ok;
            out_last  <= job_last;
            state     <= B_JOB;
          end
        end
        default: state <= B_IDLE;
      endcase
    end
  end

endmodule

// ===== rtl/core/windowed_theil_sen_speed.sv =====
`timescale 1ns / 1ps
// Windowed Theil-Sen speed estimator, top level: register file, front end, queue, back end.
// A sample passes the front end's conversion states; each slope uses the serial divider.
// A result needs one slope per window pair (up to 10 pairs) for each component: altitude only
// in vertical mode, three with GPS, then a square root; one sample yields up to three results.
// Throughput is set by the one-bit-per-cycle divider in the back end.
// Reset (rst, synchronous) restores register defaults and empties window and queue.
module windowed_theil_sen_speed import wtss_pkg::*; (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 s_tvalid,
  output logic                 s_tready,
  input  logic [127:0]         s_tdata,   // time_ms, altitude_mm, lat_udeg, lon_udeg, zero fill
  input  logic [2:0]           s_tuser,   // seg_ok, alt_ok, coord_ok
  input  logic                 s_tlast,
  output logic                 m_tvalid,
  input  logic                 m_tready,
  output logic [31:0]          m_tdata,   // speed_mm_s
  output logic [0:0]           m_tuser,   // speed_ok
  output logic                 m_tlast,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_DAT_W-1:0] cfg_data
);

  cfg_t    cfg;
  logic    f_valid;
  logic    f_ready;
  sample_t f_data;
  logic    q_valid;
  logic    q_pop;
  sample_t q_data;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.gps_mode <= 1'b0;
      cfg.ref_lat  <= '0;
      cfg.ref_lon  <= '0;
      cfg.cos_ref  <= 17'd65536;
      cfg.max_span <= 16'd5000;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_GPS_MODE: cfg.gps_mode <= cfg_data[0];
        CFG_REF_LAT:  cfg.ref_lat  <= cfg_data[27:0];
        CFG_REF_LON:  cfg.ref_lon  <= cfg_data[28:0];
        CFG_COS_REF:  cfg.cos_ref  <= cfg_data[16:0];
        CFG_MAX_SPAN: cfg.max_span <= cfg_data[15:0];
        default: ;
      endcase
    end
  end

  wtss_front u_front (
    .clk      (clk),
    .rst      (rst),
    .cfg      (cfg),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .s_tlast  (s_tlast),
    .f_valid  (f_valid),
    .f_ready  (f_ready),
    .f_data   (f_data)
  );

  wtss_fifo u_fifo (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (f_valid),
    .in_ready  (f_ready),
    .in_data   (f_data),
    .out_valid (q_valid),
    .out_pop   (q_pop),
    .out_data  (q_data)
  );

  wtss_back u_back (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .q_valid   (q_valid),
    .q_data    (q_data),
    .q_pop     (q_pop),
    .out_valid (m_tvalid),
    .out_ready (m_tready),
    .out_speed (m_tdata),
    .out_ok    (m_tuser[0]),
    .out_last  (m_tlast)
  );

endmodule

// ===== rtl/core/wtss_check.sv =====
`timescale 1ns / 1ps
// Port-level checker for the speed estimator, bound to the top level.
// Depends on windowed_theil_sen_speed.
module wtss_check (
  input logic        clk,
  input logic        rst,
  input logic        s_tvalid,
  input logic        s_tready,
  input logic        m_tvalid,
  input logic        m_tready,
  input logic [31:0] m_tdata,
  input logic [0:0]  m_tuser,
  input logic        m_tlast
);

  a_reset_clears_out: assert property (@(posedge clk) rst |=> !m_tvalid)
    else $error("result valid after reset");

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser) &&
    $stable(m_tlast))
    else $error("stalled result changed");

  a_unavail_zero: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tuser[0] |-> m_tdata == 32'd0)
    else $error("unavailable speed is not zero");

  a_front_busy: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready |=> !s_tready)
    else $error("front took a request while converting");

endmodule

bind windowed_theil_sen_speed wtss_check u_check (.*);

// ===== sim/windowed_theil_sen_speed_tb.sv =====
`timescale 1ns / 1ps
// Self-checking testbench of windowed_theil_sen_speed: directed ranges, then random ranges.
// Depends on wtss_pkg and the block; predicts every speed result in a model of its own.
module windowed_theil_sen_speed_tb;
  import wtss_pkg::*;

  localparam int WATCHDOG_LIMIT = 40000;
  localparam int HOLD_CYCLES    = 2500;
  localparam int SETTLE_CYCLES  = 60;
  localparam longint Q16_MM     = 7287271;
  localparam longint LAT_MAX    = 90000000;
  localparam longint LON_MAX    = 180000000;
  localparam longint TURN       = 360000000;
  localparam logic [CFG_IDX_W-1:0] CFG_UNUSED = 3'd7;

  typedef struct {
    bit        seg_ok;
    bit [31:0] t_ms;
    bit [31:0] alt_mm;
    bit        alt_ok;
    bit        coord_ok;
    bit [27:0] lat;
    bit [28:0] lon;
    bit        fin;
  } in_item_t;

  typedef struct {
    bit [31:0] speed;
    bit        ok;
    bit        fin;
  } speed_item_t;

  logic                 clk = 1'b0;
  logic                 rst = 1'b1;
  logic                 s_tvalid = 1'b0;
  logic                 s_tready;
  logic [127:0]         s_tdata = '0;  // time_ms, altitude_mm, lat_udeg, lon_udeg, zero fill
  logic [2:0]           s_tuser = '0;  // seg_ok, alt_ok, coord_ok
  logic                 s_tlast = 1'b0;
  logic                 m_tvalid;
  logic                 m_tready = 1'b0;
  logic [31:0]          m_tdata;       // speed_mm_s
  logic [0:0]           m_tuser;       // speed_ok
  logic                 m_tlast;
  logic                 cfg_valid = 1'b0;
  logic                 cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CFG_DAT_W-1:0] cfg_data = '0;

  in_item_t    pending_samples[$];
  speed_item_t expected_speeds[$];
  in_item_t    on_bus;
  int          errors = 0;
  int          snd_idle = 0;
  int          rcv_idle = 0;
  bit          hold_go = 0;
  int          hold_left = 0;
  int          quiet_cycles = 0;

  // Model copy of registers and window.
  bit          m_gps;
  longint      m_ref_lat, m_ref_lon;
  longint      m_cos, m_span;
  bit   [31:0] w_time[WIN_LEN];
  longint      w_alt[WIN_LEN], w_east[WIN_LEN], w_north[WIN_LEN];
  bit   [2:0]  w_flags[WIN_LEN];
  int          w_fill;

  windowed_theil_sen_speed i_dut (.*);

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic longint q16_scale(longint a, longint k);
    longint unsigned mag, p;
    mag = a < 0 ? -a : a;
    p = (mag * k + 32768) >> 16;
    return a < 0 ? -longint'(p) : longint'(p);
  endfunction

  function automatic longint clamp32(longint v);
    if (v > 64'sd2147483647) return 64'sd2147483647;
    if (v < -64'sd2147483648) return -64'sd2147483648;
    return v;
  endfunction

  function automatic longint wrap_dlon(longint d);
    longint q, r;
    q = d / TURN;
    r = d % TURN;
    if (r < 0) begin
      r += TURN;
      q -= 1;
    end
    if (r > LON_MAX) r -= TURN;
    else if (r == LON_MAX && q[0]) r = -LON_MAX;
    return r;
  endfunction

  function automatic longint unsigned int_sqrt(longint unsigned x);
    longint unsigned r, b;
    r = 0;
    b = 64'd1 << 62;
    while (b > x) b >>= 2;
    while (b != 0) begin
      if (x >= r + b) begin
        x -= r + b;
        r = (r >> 1) + b;
      end else r >>= 1;
      b >>= 2;
    end
    return r;
  endfunction

  function automatic bit median_slope(longint v[WIN_LEN], int l, int r, output longint res);
    longint s[MAX_PAIRS];
    longint dt, x;
    int n, j;
    n = 0;
    res = 0;
    for (int a = l; a < r; a++)
      for (int b = a + 1; b <= r; b++) begin
        dt = longint'(w_time[b]) - longint'(w_time[a]);
        if (dt <= 0) return 0;
        x = (v[b] - v[a]) * 1000 / dt;
        j = n;
        while (j > 0 && s[j-1] > x) begin
          s[j] = s[j-1];
          j--;
        end
        s[j] = x;
        n++;
      end
    if (n == 0) return 0;
    res = n % 2 ? s[n/2] : (s[n/2-1] + s[n/2]) / 2;
    return 1;
  endfunction

  function automatic bit window_speed(int l, int r, output bit [31:0] spd);
    longint vz, vx, vy, c;
    longint unsigned m, sq, sum;
    spd = 0;
    if (r - l + 1 < MIN_POINTS) return 0;
    for (int i = l + 1; i <= r; i++) if (!w_flags[i][FLAG_SEG]) return 0;
    if (longint'(w_time[r]) - longint'(w_time[l]) > m_span) return 0;
    for (int i = l; i <= r; i++) if (!w_flags[i][FLAG_ALT]) return 0;
    if (!median_slope(w_alt, l, r, vz)) return 0;
    if (!m_gps) begin
      m = vz < 0 ? -vz : vz;
      spd = m > 64'hFFFFFFFF ? 32'hFFFFFFFF : m[31:0];
      return 1;
    end
    for (int i = l; i <= r; i++) if (!w_flags[i][FLAG_POS]) return 0;
    if (!median_slope(w_east, l, r, vx)) return 0;
    if (!median_slope(w_north, l, r, vy)) return 0;
    sum = 0;
    for (int k = 0; k < 3; k++) begin
      c = k == 0 ? vx : k == 1 ? vy : vz;
      m = c < 0 ? -c : c;
      if (m > 64'hFFFFFFFF) begin
        spd = 32'hFFFFFFFF;
        return 1;
      end
      sq = m * m;
      if (sum > 64'hFFFFFFFFFFFFFFFF - sq) begin
        spd = 32'hFFFFFFFF;
        return 1;
      end
      sum += sq;
    end
    spd = 32'(int_sqrt(sum));
    return 1;
  endfunction

  function automatic void owe_speed(int l, int r, bit fin);
    speed_item_t e;
    bit [31:0] spd;
    e.ok = window_speed(l, r, spd);
    e.speed = e.ok ? spd : 32'd0;
    e.fin = fin;
    expected_speeds = {expected_speeds, e};
  endfunction

  function automatic void predict_speeds(in_item_t s);
    longint lat, lon, e;
    bit pos_ok;
    int f, p, c;
    lat = longint'(signed'(s.lat));
    lon = longint'(signed'(s.lon));
    pos_ok = s.coord_ok && lat <= LAT_MAX && lat >= -LAT_MAX && lon <= LON_MAX &&
             lon >= -LON_MAX && !(lat == 0 && lon == 0);
    f = w_fill;
    if (f == WIN_LEN) begin
      for (int i = 0; i + 1 < WIN_LEN; i++) begin
        w_time[i] = w_time[i+1];
        w_alt[i] = w_alt[i+1];
        w_east[i] = w_east[i+1];
        w_north[i] = w_north[i+1];
        w_flags[i] = w_flags[i+1];
      end
      p = WIN_LEN - 1;
    end else begin
      p = f;
      f++;
    end
    w_time[p] = s.t_ms;
    w_alt[p] = longint'(signed'(s.alt_mm));
    w_east[p] = 0;
    w_north[p] = 0;
    if (pos_ok) begin
      e = q16_scale(wrap_dlon(lon - m_ref_lon), Q16_MM);
      w_east[p] = clamp32(q16_scale(e, m_cos));
      w_north[p] = clamp32(q16_scale(lat - m_ref_lat, Q16_MM));
    end
    w_flags[p] = '0;
    w_flags[p][FLAG_SEG] = s.seg_ok;
    w_flags[p][FLAG_ALT] = s.alt_ok;
    w_flags[p][FLAG_POS] = pos_ok;
    w_fill = f;
    if (f >= HALF_WIDTH + 1) owe_speed(0, f - 1, 0);
    if (s.fin) begin
      c = f >= HALF_WIDTH + 1 ? f - HALF_WIDTH : 0;
      for (; c < f; c++) owe_speed(c >= HALF_WIDTH ? c - HALF_WIDTH : 0, f - 1, c == f - 1);
      w_fill = 0;
    end
  endfunction

  // Sender.
  always @(posedge clk) begin
    if (rst) begin
      s_tvalid <= 1'b0;
    end else begin
      if (s_tvalid && s_tready) predict_speeds(on_bus);
      if (!s_tvalid || s_tready) begin
        if (pending_samples.size() != 0 && $urandom_range(99) >= snd_idle) begin
          on_bus = pending_samples.pop_front();
          s_tdata <= {7'd0, on_bus.lon, on_bus.lat, on_bus.alt_mm, on_bus.t_ms};
          s_tuser <= {on_bus.coord_ok, on_bus.alt_ok, on_bus.seg_ok};
          s_tlast <= on_bus.fin;
          s_tvalid <= 1'b1;
        end else begin
          s_tvalid <= 1'b0;
        end
      end
    end
  end

  // Receiver readiness, with one long hold-off on request.
  always @(posedge clk) begin
    if (rst) begin
      m_tready <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left--;
      m_tready <= 1'b0;
    end else if (hold_go) begin
      hold_go = 0;
      hold_left = HOLD_CYCLES;
      m_tready <= 1'b0;
    end else begin
      m_tready <= $urandom_range(99) >= rcv_idle;
    end
  end

  // Result checker.
  always @(posedge clk) begin
    speed_item_t e;
    if (!rst && m_tvalid && m_tready) begin
      if (expected_speeds.size() == 0) begin
        $display("%0t: unexpected speed %0d ok %0d last %0d", $time, m_tdata, m_tuser, m_tlast);
        errors++;
      end else begin
        e = expected_speeds.pop_front();
        if (m_tdata !== e.speed) begin
          $display("%0t: speed expected %0d actual %0d", $time, e.speed, m_tdata);
          errors++;
        end
        if (m_tuser[0] !== e.ok) begin
          $display("%0t: speed_ok expected %0d actual %0d", $time, e.ok, m_tuser);
          errors++;
        end
        if (m_tlast !== e.fin) begin
          $display("%0t: last expected %0d actual %0d", $time, e.fin, m_tlast);
          errors++;
        end
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
      quiet_cycles <= 0;
    else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("windowed_theil_sen_speed_tb: done, errors");
      $finish;
    end else quiet_cycles <= quiet_cycles + 1;
  end

  task automatic add_sample(bit seg, bit [31:0] t, bit [31:0] alt, bit aok, bit cok,
                            bit [27:0] lat, bit [28:0] lon, bit fin);
    in_item_t s;
    s = '{seg, t, alt, aok, cok, lat, lon, fin};
    pending_samples = {pending_samples, s};
  endtask

  // Writes a list of registers; valid drops only after the last one.
  task automatic write_regs(logic [CFG_IDX_W-1:0] idx[], logic [CFG_DAT_W-1:0] val[]);
    foreach (idx[i]) begin
      cfg_index <= idx[i];
      cfg_data <= val[i];
      cfg_valid <= 1'b1;
      do @(posedge clk); while (!cfg_ready);
      case (idx[i])
        CFG_GPS_MODE: m_gps = val[i][0];
        CFG_REF_LAT:  m_ref_lat = longint'(signed'(val[i][27:0]));
        CFG_REF_LON:  m_ref_lon = longint'(signed'(val[i][28:0]));
        CFG_COS_REF:  m_cos = val[i][16:0];
        CFG_MAX_SPAN: m_span = val[i][15:0];
        default: ;
      endcase
    end
    cfg_valid <= 1'b0;
  endtask

  task automatic drain();
    while (pending_samples.size() != 0 || s_tvalid || expected_speeds.size() != 0)
      @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // One range: mostly a smooth track near the reference, with some broken or noisy samples.
  task automatic add_range(int n);
    bit [31:0] t;
    longint alt, lat, lon;
    t = $urandom_range(9) == 0 ? $urandom : $urandom_range(100000);
    alt = $urandom_range(2000000) - 1000000;
    lat = m_ref_lat + $urandom_range(20000) - 10000;
    lon = m_ref_lon + $urandom_range(20000) - 10000;
    for (int i = 0; i < n; i++) begin
      t += $urandom_range(5) == 0 ? $urandom_range(3000) : $urandom_range(1200, 20);
      alt += $urandom_range(5) == 0 ? $urandom_range(4000000) - 2000000
                                    : $urandom_range(60000) - 30000;
      lat += $urandom_range(4000) - 2000;
      lon += $urandom_range(4000) - 2000;
      if ($urandom_range(9) == 0)
        add_sample($urandom, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom,
                   i == n - 1);
      else
        add_sample($urandom_range(19) != 0, t, alt, $urandom_range(24) != 0,
                   $urandom_range(24) != 0, lat, lon, i == n - 1);
    end
  endtask

  initial begin
    int n;
    m_gps = 0;
    m_ref_lat = 0;
    m_ref_lon = 0;
    m_cos = 65536;
    m_span = 5000;
    w_fill = 0;
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    snd_idle = 11;
    rcv_idle = 84;

    // Vertical mode at reset settings: short ranges, extremes, broken windows.
    add_sample(1, 0, 0, 1, 1, 1000, 1000, 1);
    add_sample(0, 100, 5, 1, 1, 1000, 1000, 0);
    add_sample(1, 200, 9, 1, 1, 1000, 1000, 1);
    add_sample(1, 1000, 32'h7FFFFFFF, 1, 0, 0, 0, 0);
    add_sample(1, 1001, 32'h80000000, 1, 0, 0, 0, 0);
    add_sample(1, 1002, 32'h7FFFFFFF, 1, 0, 0, 0, 1);
    add_sample(1, 5, 10, 1, 0, 0, 0, 0);
    add_sample(1, 5, 20, 1, 0, 0, 0, 0);
    add_sample(1, 6, 30, 1, 0, 0, 0, 0);
    add_sample(1, 7, 40, 1, 0, 0, 0, 1);
    for (int i = 0; i < 5; i++) add_sample(1, i * 2000, i * 700, 1, 0, 0, 0, i == 4);
    for (int i = 0; i < 6; i++)
      add_sample(i != 2, 100 * i, -300 * i, i != 4, 0, 0, 0, i == 5);
    add_sample(1, 32'hFFFFFFFD, 0, 1, 0, 0, 0, 0);
    add_sample(1, 32'hFFFFFFFE, 1000, 1, 0, 0, 0, 0);
    add_sample(1, 32'hFFFFFFFF, 3000, 1, 0, 0, 0, 1);
    drain();

    // GPS mode: globe edges, longitude wrap tie, the zero position, invalid positions.
    write_regs('{CFG_GPS_MODE, CFG_REF_LON, CFG_MAX_SPAN, CFG_UNUSED},
               '{1, -29'sd8000000, 65535, 29'h1FFFFFFF});
    add_sample(1, 0, 0, 1, 1, 90000000, 172000000, 0);
    add_sample(1, 1000, 100, 1, 1, 89999000, -180000000, 0);
    add_sample(1, 2000, 300, 1, 1, 89998000, 180000000, 1);
    add_sample(1, 0, 0, 1, 1, 0, 0, 0);
    add_sample(1, 500, 0, 1, 1, 5, 5, 0);
    add_sample(1, 900, 0, 1, 1, 9, 9, 1);
    add_sample(1, 0, 0, 1, 1, 90000001, 5, 0);
    add_sample(1, 10, 0, 1, 0, 5, 5, 0);
    add_sample(1, 20, 0, 1, 1, -90000000, -180000001, 1);
    drain();

    for (int ph = 0; ph < 7; ph++) begin
      case (ph)
        0: write_regs('{CFG_GPS_MODE, CFG_MAX_SPAN}, '{0, 1});
        1: write_regs('{CFG_GPS_MODE, CFG_REF_LAT, CFG_REF_LON, CFG_COS_REF, CFG_MAX_SPAN},
                      '{1, 51000000, -8000000, 41000, 5000});
        2: write_regs('{CFG_GPS_MODE, CFG_MAX_SPAN}, '{0, 65535});
        3: write_regs('{CFG_GPS_MODE, CFG_REF_LAT, CFG_REF_LON, CFG_COS_REF, CFG_MAX_SPAN},
                      '{1, 28'h8000000, 29'h0FFFFFFF, 131071, 0});
        4: write_regs('{CFG_GPS_MODE, CFG_REF_LAT, CFG_REF_LON, CFG_COS_REF, CFG_MAX_SPAN},
                      '{1, -28'sd90000000, 29'sd180000000, 0, 4000});
        5: write_regs('{CFG_GPS_MODE, CFG_REF_LAT, CFG_REF_LON, CFG_COS_REF, CFG_MAX_SPAN},
                      '{0, 90000000, -29'sd180000000, 65536, 3000});
        default: write_regs('{CFG_GPS_MODE, CFG_REF_LAT, CFG_REF_LON, CFG_COS_REF},
                            '{1, 28'h7FFFFFF, 29'h10000000, 30000});
      endcase
      if (ph == 2) begin
        snd_idle = 84;
        rcv_idle = 11;
      end else if (ph == 4) begin
        snd_idle = 0;
        rcv_idle = 0;
      end
      if (ph == 3) hold_go = 1;
      n = 0;
      while (n < 50) begin
        int len;
        len = $urandom_range(7) == 0 ? $urandom_range(2, 1) : $urandom_range(14, 3);
        add_range(len);
        n += len;
      end
      drain();
    end

    if (errors == 0 && expected_speeds.size() == 0)
      $display("windowed_theil_sen_speed_tb: done, clean");
    else
      $display("windowed_theil_sen_speed_tb: done, errors");
    $finish;
  end

endmodule

// ===== sim.f =====
rtl/core/wtss_pkg.sv
rtl/core/wtss_front.sv
rtl/core/wtss_fifo.sv
rtl/core/wtss_back.sv
rtl/core/windowed_theil_sen_speed.sv
rtl/core/wtss_check.sv
sim/windowed_theil_sen_speed_tb.sv
